@@ sv/mmc_pkg.sv @@
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants for the memory map controller
// Command and target codes, decode constants and the memory mirror masks.
// ----------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 24;
  localparam int DATA_W    = 8;
  localparam int TGT_W     = 2;
  localparam int MADDR_W   = 23;
  localparam int NUM_REGS  = 16;
  localparam int REG_IDX_W = 4;

  // Packed channel widths
  localparam int IN_TDATA_W  = 32;  // bus_addr, wdata
  localparam int OUT_TDATA_W = 32;  // rdata, mem_addr, mem_write

  // Access kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_REG_RD = 2'd0,
    CMD_REG_WR = 2'd1,
    CMD_MCU_RD = 2'd2,
    CMD_MCU_WR = 2'd3
  } cmd_t;

  // Target memories
  typedef enum logic [TGT_W-1:0] {
    TGT_NONE  = 2'd0,
    TGT_ROM   = 2'd1,
    TGT_RAM   = 2'd2,
    TGT_FLASH = 2'd3
  } tgt_t;

  // Control register window: banks 00-0F, offset 5000
  localparam logic [ADDR_W-1:0] REG_WIN_MASK  = 24'hf0ffff;
  localparam logic [ADDR_W-1:0] REG_WIN_MATCH = 24'h005000;

  // Register indexes with special meaning
  localparam logic [REG_IDX_W-1:0] REG_COMMIT = 4'he;

  // Committed mode bit positions
  localparam int CB_FLASH_RAM  = 1;
  localparam int CB_FLASH_LIN  = 2;
  localparam int CB_RAM_BANK6  = 3;
  localparam int CB_RAM_BANK4  = 5;
  localparam int CB_RAM_BANK5  = 6;
  localparam int CB_ROM_LO     = 7;
  localparam int CB_ROM_HI     = 8;

  // Region decode constants
  localparam logic [ADDR_W-1:0] ROM_REG_MASK   = 24'he08000;
  localparam logic [ADDR_W-1:0] ROM_LO_MATCH   = 24'h008000;
  localparam logic [ADDR_W-1:0] ROM_HI_MATCH   = 24'h808000;
  localparam logic [ADDR_W-1:0] BANK_MASK      = 24'hf00000;
  localparam logic [ADDR_W-1:0] RAM4_MATCH     = 24'h400000;
  localparam logic [ADDR_W-1:0] RAM5_MATCH     = 24'h500000;
  localparam logic [ADDR_W-1:0] RAM6_MATCH     = 24'h600000;
  localparam logic [ADDR_W-1:0] RAM7_MASK      = 24'hf80000;
  localparam logic [ADDR_W-1:0] RAM7_MATCH     = 24'h700000;
  localparam logic [ADDR_W-1:0] FLASH_LO_MASK  = 24'h408000;
  localparam logic [ADDR_W-1:0] FLASH_LO_MATCH = 24'h008000;
  localparam logic [ADDR_W-1:0] HIGH_HALF      = 24'h400000;

  // Memory sizes as address bits
  localparam int ROM_ADDR_BITS   = 22;
  localparam int RAM_ADDR_BITS   = 19;
  localparam int FLASH_ADDR_BITS = 20;

  localparam logic [MADDR_W-1:0] ROM_MIRROR =
    MADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
  localparam logic [MADDR_W-1:0] RAM_MIRROR =
    MADDR_W'((64'd1 << RAM_ADDR_BITS) - 64'd1);
  localparam logic [MADDR_W-1:0] FLASH_MIRROR =
    MADDR_W'((64'd1 << FLASH_ADDR_BITS) - 64'd1);

  // Reset values
  localparam logic [DATA_W-1:0]   REG_RST_ROM = 8'h80;
  localparam logic [NUM_REGS-1:0] CB_RST      = 16'h0180;

endpackage : mmc_pkg

`default_nettype wire

@@ sv/memory_map_controller_unit.sv @@
// ----------------------------------------------------------------------------
// memory_map_controller_unit: bank-mapping controller
// Holds sixteen control registers and the committed mode bits, serves
// register reads and writes, and decodes MCU accesses into a target memory
// and a mirrored memory address.
//
// Pipeline: an accepted item passes the input register, then the result
// register. Throughput: one item per cycle while the result channel is
// not stalled; the input side stays ready while a result waits as long
// as the result register drains.
// Reset: synchronous, active low; clears the pipeline and restores the
// control registers (entries 7 and 8 = 0x80) and committed bits (7 and 8).
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_controller_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mmc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [23:0] bus_addr, [31:24] wdata
  input  wire logic [mmc_pkg::CMD_W-1:0]       in_tuser,   // [1:0] cmd
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mmc_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [7:0] rdata, [30:8] mem_addr,
                                                           // [31] mem_write
  output logic [mmc_pkg::TGT_W-1:0]            out_tuser   // [1:0] target
);

  import mmc_pkg::*;

  // Input register
  logic                 s1_valid_r;
  cmd_t                 s1_cmd_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic [DATA_W-1:0]    s1_wdata_r;

  // Result register
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_rdata_r;
  tgt_t                 out_tgt_r;
  logic [MADDR_W-1:0]   out_maddr_r;
  logic                 out_mwr_r;

  // Block state
  logic [DATA_W-1:0]    ctrl_r [NUM_REGS];
  logic [DATA_W-1:0]    ctrl_nxt [NUM_REGS];
  logic [NUM_REGS-1:0]  cb_r;
  logic [NUM_REGS-1:0]  cb_nxt;

  // Handshake
  logic                 out_load;
  logic                 s1_adv;

  // Decode results
  logic                 reg_hit;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [ADDR_W-1:0]    a_exp;
  tgt_t                 tgt;
  logic [MADDR_W-1:0]   t_addr;
  logic [MADDR_W-1:0]   maddr;
  logic [DATA_W-1:0]    rdata;
  logic                 mwr;
  logic                 is_mcu;

  // Pipeline flow: advance when the result register is free or draining
  assign out_load  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r   <= cmd_t'(in_tuser);
      s1_addr_r  <= in_tdata[ADDR_W-1:0];
      s1_wdata_r <= in_tdata[ADDR_W +: DATA_W];
    end
  end

  // Register window decode
  assign reg_hit = (s1_addr_r & REG_WIN_MASK) == REG_WIN_MATCH;
  assign reg_idx = s1_addr_r[16 +: REG_IDX_W];
  assign is_mcu  = (s1_cmd_r == CMD_MCU_RD) || (s1_cmd_r == CMD_MCU_WR);

  // Expand addresses with bits 23:22 clear to the banked form
  always_comb begin
    if (s1_addr_r[23:22] == 2'b00) begin
      a_exp = {s1_addr_r[21], 1'b0, s1_addr_r[20:15], 1'b1, s1_addr_r[14:0]};
    end else begin
      a_exp = s1_addr_r;
    end
  end

  // Region rules, in priority order
  always_comb begin
    tgt    = TGT_NONE;
    t_addr = '0;
    if ((a_exp & ROM_REG_MASK) == ROM_LO_MATCH && cb_r[CB_ROM_LO]) begin
      tgt    = TGT_ROM;
      t_addr = {3'b000, a_exp[20:16], a_exp[14:0]};
    end else if ((a_exp & ROM_REG_MASK) == ROM_HI_MATCH && cb_r[CB_ROM_HI]) begin
      tgt    = TGT_ROM;
      t_addr = {3'b000, a_exp[20:16], a_exp[14:0]};
    end else if ((a_exp & BANK_MASK) == RAM4_MATCH && !cb_r[CB_RAM_BANK4]) begin
      tgt    = TGT_RAM;
      t_addr = {3'b000, a_exp[19:0]};
    end else if ((a_exp & BANK_MASK) == RAM5_MATCH && !cb_r[CB_RAM_BANK5]) begin
      tgt    = TGT_RAM;
      t_addr = {3'b000, a_exp[19:0]};
    end else if ((a_exp & BANK_MASK) == RAM6_MATCH && cb_r[CB_RAM_BANK6]) begin
      tgt    = TGT_RAM;
      t_addr = {3'b000, a_exp[19:0]};
    end else if ((a_exp & RAM7_MASK) == RAM7_MATCH) begin
      tgt    = TGT_RAM;
      t_addr = {4'b0000, a_exp[18:0]};
    end else if ((a_exp & FLASH_LO_MASK) == FLASH_LO_MATCH ||
                 (a_exp & HIGH_HALF) == HIGH_HALF) begin
      tgt = cb_r[CB_FLASH_RAM] ? TGT_RAM : TGT_FLASH;
      if (cb_r[CB_FLASH_LIN]) begin
        t_addr = a_exp[MADDR_W-1:0];
      end else begin
        t_addr = {1'b0, a_exp[22:16], a_exp[14:0]};
      end
    end
  end

  // Mirror into the target memory size
  always_comb begin
    case (tgt)
      TGT_ROM:   maddr = t_addr & ROM_MIRROR;
      TGT_RAM:   maddr = t_addr & RAM_MIRROR;
      TGT_FLASH: maddr = t_addr & FLASH_MIRROR;
      default:   maddr = '0;
    endcase
  end

  // Result data
  always_comb begin
    rdata = '0;
    mwr   = 1'b0;
    case (s1_cmd_r)
      CMD_REG_RD: rdata = reg_hit ? ctrl_r[reg_idx] : s1_wdata_r;
      CMD_MCU_WR: mwr   = (tgt != TGT_NONE);
      default:    rdata = '0;
    endcase
  end

  // Register write and commit
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      ctrl_nxt[i] = ctrl_r[i];
    end
    cb_nxt = cb_r;
    if (s1_adv && s1_cmd_r == CMD_REG_WR && reg_hit) begin
      ctrl_nxt[reg_idx] = s1_wdata_r;
      if (reg_idx == REG_COMMIT && s1_wdata_r[DATA_W-1]) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          cb_nxt[i] = ctrl_nxt[i][DATA_W-1];
        end
      end
    end
  end

  // Hold the control registers and committed bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_r[i] <= '0;
      end
      ctrl_r[CB_ROM_LO] <= REG_RST_ROM;
      ctrl_r[CB_ROM_HI] <= REG_RST_ROM;
      cb_r              <= CB_RST;
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_r[i] <= ctrl_nxt[i];
      end
      cb_r <= cb_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rdata_r <= rdata;
      out_tgt_r   <= is_mcu ? tgt : TGT_NONE;
      out_maddr_r <= is_mcu ? maddr : '0;
      out_mwr_r   <= mwr;
    end
  end

  // Drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mwr_r, out_maddr_r, out_rdata_r};
  assign out_tuser  = out_tgt_r;

endmodule : memory_map_controller_unit

`default_nettype wire

@@ tb/memory_map_controller_unit_tb.sv @@
// ----------------------------------------------------------------------------
// memory_map_controller_unit_tb: self-checking bench for the bank mapper
// Drives register and MCU accesses through the input stream with random
// gaps, predicts each decoded result from a local copy of the control
// registers and committed mode bits, and checks every result field.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmc_pkg::*;

  localparam int RANDOM_ACCESSES = 1550;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 4;

  typedef struct {
    cmd_t                op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } bus_access_t;

  typedef struct {
    logic [DATA_W-1:0]   rdata;
    tgt_t                target;
    logic [MADDR_W-1:0]  mem_addr;
    logic                mem_write;
  } map_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = CMD_REG_RD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [TGT_W-1:0]       out_tuser;

  // Local copy of the mapper state
  logic [DATA_W-1:0]   ctrl_regs [NUM_REGS];
  logic [NUM_REGS-1:0] mode_bits;

  bus_access_t access_queue[$];
  map_result_t decode_queue[$];
  bus_access_t cur_access;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  memory_map_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [23:0] bus_addr, [31:24] wdata
    .in_tuser   (in_tuser),   // [1:0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] rdata, [30:8] mem_addr, [31] mem_write
    .out_tuser  (out_tuser)   // [1:0] target
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one access to the local state and return its decoded result
  function automatic map_result_t decode_access(cmd_t op, logic [ADDR_W-1:0] a,
                                                logic [DATA_W-1:0] d);
    map_result_t        res;
    logic [ADDR_W-1:0]  x;
    logic [MADDR_W-1:0] raw;
    logic [REG_IDX_W-1:0] idx;
    logic               hit;
    res = '{rdata: '0, target: TGT_NONE, mem_addr: '0, mem_write: 1'b0};
    hit = (a & REG_WIN_MASK) == REG_WIN_MATCH;
    idx = a[19:16];
    case (op)
      CMD_REG_RD: res.rdata = hit ? ctrl_regs[idx] : d;
      CMD_REG_WR: begin
        if (hit) begin
          ctrl_regs[idx] = d;
          // latch bit 7 of every register into the mode bits
          if (idx == REG_COMMIT && d[7]) begin
            for (int i = 0; i < NUM_REGS; i++) mode_bits[i] = ctrl_regs[i][7];
          end
        end
      end
      default: begin
        // expand addresses with bits 23:22 clear into the banked form first
        x = a;
        if (a[23:22] == 2'b00) x = {a[21], 1'b0, a[20:15], 1'b1, a[14:0]};
        raw = '0;
        if (((x & ROM_REG_MASK) == ROM_LO_MATCH && mode_bits[CB_ROM_LO]) ||
            ((x & ROM_REG_MASK) == ROM_HI_MATCH && mode_bits[CB_ROM_HI])) begin
          res.target = TGT_ROM;
          raw = {3'b000, x[20:16], x[14:0]};
        end else if (((x & BANK_MASK) == RAM4_MATCH && !mode_bits[CB_RAM_BANK4]) ||
                     ((x & BANK_MASK) == RAM5_MATCH && !mode_bits[CB_RAM_BANK5]) ||
                     ((x & BANK_MASK) == RAM6_MATCH && mode_bits[CB_RAM_BANK6])) begin
          res.target = TGT_RAM;
          raw = {3'b000, x[19:0]};
        end else if ((x & RAM7_MASK) == RAM7_MATCH) begin
          res.target = TGT_RAM;
          raw = {4'b0000, x[18:0]};
        end else if ((x & FLASH_LO_MASK) == FLASH_LO_MATCH || (x & HIGH_HALF) != '0) begin
          raw = mode_bits[CB_FLASH_LIN] ? x[22:0] : {1'b0, x[22:16], x[14:0]};
          res.target = mode_bits[CB_FLASH_RAM] ? TGT_RAM : TGT_FLASH;
        end
        case (res.target)
          TGT_ROM:   res.mem_addr = raw & ROM_MIRROR;
          TGT_RAM:   res.mem_addr = raw & RAM_MIRROR;
          TGT_FLASH: res.mem_addr = raw & FLASH_MIRROR;
          default:   res.mem_addr = '0;
        endcase
        res.mem_write = (op == CMD_MCU_WR) && (res.target != TGT_NONE);
      end
    endcase
    return res;
  endfunction

  // Gap length: mostly none or short, a few long; none in calm stretches
  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(logic [REG_IDX_W-1:0] idx);
    return REG_WIN_MATCH | (ADDR_W'(idx) << 16);
  endfunction

  // MCU address biased toward the decoded regions
  function automatic logic [ADDR_W-1:0] mcu_addr();
    logic [ADDR_W-1:0] r;
    r = ADDR_W'($urandom);
    case ($urandom_range(0, 4))
      0:       return r;
      1:       return {2'b00, r[21:0]};
      2:       return {2'b01, r[21:0]};
      3:       return {r[23], 2'b00, r[20:16], 1'b1, r[14:0]};
      default: return {5'b01110, r[18:0]};
    endcase
  endfunction

  task automatic queue_access(cmd_t op, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    access_queue.push_back('{op: op, addr: a, data: d});
    n_pushed++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    n_errors++;
  endtask

  task automatic wait_drain();
    while (n_accepted != n_pushed || decode_queue.size() != 0) @(posedge clk);
  endtask

  task automatic push_random_access();
    int sel;
    logic [REG_IDX_W-1:0] idx;
    logic [DATA_W-1:0] val;
    logic [ADDR_W-1:0] a;
    sel = $urandom_range(0, 99);
    idx = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
    val = DATA_W'($urandom);
    if (sel < 18) begin
      queue_access(CMD_REG_WR, reg_addr(idx), val);
    end else if (sel < 23) begin
      queue_access(CMD_REG_WR, reg_addr(REG_COMMIT), val | 8'h80);
    end else if (sel < 33) begin
      queue_access(CMD_REG_RD, reg_addr(idx), val);
    end else if (sel < 40) begin
      // near-miss or random register accesses
      a = sel[0] ? reg_addr(idx) ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1))
                 : ADDR_W'($urandom);
      queue_access(sel[1] ? CMD_REG_WR : CMD_REG_RD, a, val);
    end else begin
      queue_access(sel[0] ? CMD_MCU_WR : CMD_MCU_RD, mcu_addr(), val);
    end
  endtask

  // Input driver: predict on accept, then present the next item or idle
  always @(posedge clk) begin : access_driver
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_queue.push_back(decode_access(cur_access.op, cur_access.addr,
                                             cur_access.data));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (access_queue.size() != 0) begin
          cur_access = access_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_access.data, cur_access.addr};
          in_tuser  <= cur_access.op;
          if ($urandom_range(0, 99) == 0) calm_in = !calm_in;
          gap_left = gap_len(calm_in);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result, stall the output at random
  always @(posedge clk) begin : result_monitor
    map_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (decode_queue.size() == 0) begin
          report_mismatch("result with nothing pending", 32'h0, out_tdata);
        end else begin
          want = decode_queue.pop_front();
          if (out_tdata[7:0] != want.rdata)
            report_mismatch("rdata", want.rdata, out_tdata[7:0]);
          if (out_tuser != want.target)
            report_mismatch("target", want.target, out_tuser);
          if (out_tdata[30:8] != want.mem_addr)
            report_mismatch("mem_addr", want.mem_addr, out_tdata[30:8]);
          if (out_tdata[31] != want.mem_write)
            report_mismatch("mem_write", want.mem_write, out_tdata[31]);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
        stall_left = gap_len(calm_out);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    bit all_set;
    bit drained_mid;
    drained_mid = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) ctrl_regs[i] = '0;
    ctrl_regs[CB_ROM_LO] = REG_RST_ROM;
    ctrl_regs[CB_ROM_HI] = REG_RST_ROM;
    for (int i = 0; i < NUM_REGS; i++) mode_bits[i] = ctrl_regs[i][7];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, open-bus reads, every region, commit behavior
    queue_access(CMD_REG_RD, 24'h075000, 8'hff);
    queue_access(CMD_REG_RD, 24'h000000, 8'ha5);
    queue_access(CMD_MCU_RD, 24'h000000, 8'hff);
    queue_access(CMD_MCU_RD, 24'hffffff, 8'h00);
    queue_access(CMD_MCU_WR, 24'h808000, 8'h3c);
    queue_access(CMD_MCU_RD, 24'h400123, 8'h00);
    queue_access(CMD_MCU_WR, 24'h5abcde, 8'hff);
    queue_access(CMD_MCU_RD, 24'h612345, 8'h00);
    queue_access(CMD_MCU_WR, 24'h77ffff, 8'h5a);
    queue_access(CMD_MCU_RD, 24'h7fffff, 8'h00);
    queue_access(CMD_MCU_RD, 24'h200000, 8'h00);
    queue_access(CMD_MCU_RD, 24'h800000, 8'hff);
    queue_access(CMD_MCU_WR, 24'h800000, 8'hff);
    // write outside the window is dropped
    queue_access(CMD_REG_WR, 24'h105000, 8'h11);
    queue_access(CMD_REG_RD, 24'h105000, 8'h00);
    queue_access(CMD_REG_WR, 24'h015000, 8'h80);
    queue_access(CMD_REG_WR, 24'h025000, 8'h80);
    queue_access(CMD_REG_WR, 24'h035000, 8'h80);
    queue_access(CMD_REG_WR, 24'h055000, 8'h80);
    queue_access(CMD_REG_WR, 24'h065000, 8'h80);
    queue_access(CMD_REG_WR, 24'h075000, 8'h00);
    queue_access(CMD_REG_WR, 24'h085000, 8'h00);
    // no commit without bit 7, so mapping holds
    queue_access(CMD_REG_WR, 24'h0e5000, 8'h7f);
    queue_access(CMD_MCU_RD, 24'h008000, 8'h00);
    queue_access(CMD_REG_WR, 24'h0e5000, 8'hff);
    queue_access(CMD_MCU_RD, 24'h008000, 8'h00);
    queue_access(CMD_MCU_RD, 24'h400000, 8'h00);
    queue_access(CMD_MCU_RD, 24'h600000, 8'h00);
    wait_drain();

    // Random part, with one full drain halfway
    while (n_pushed < RANDOM_ACCESSES) begin
      if (!drained_mid && n_pushed >= RANDOM_ACCESSES / 2) begin
        wait_drain();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) begin
        // rewrite all registers with bit 7 uniform, then commit
        all_set = $urandom_range(0, 1);
        for (int i = 0; i < NUM_REGS; i++)
          queue_access(CMD_REG_WR, reg_addr(REG_IDX_W'(i)),
                       all_set ? DATA_W'($urandom) | 8'h80 : DATA_W'($urandom) & 8'h7f);
        queue_access(CMD_REG_WR, reg_addr(REG_COMMIT), DATA_W'($urandom) | 8'h80);
      end else begin
        push_random_access();
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : memory_map_controller_unit_tb

`default_nettype wire

@@ memory_map_controller_unit.f @@
sv/mmc_pkg.sv
sv/memory_map_controller_unit.sv
tb/memory_map_controller_unit_tb.sv
